// ===== sv/windowed_event_counter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed event counter
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_EVENT_COUNTER_UNIT_ASSERT_SVH
`define WINDOWED_EVENT_COUNTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wec_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed event counter package
// Shared widths, codes and the control word of the entry chain.
// ----------------------------------------------------------------------------
package wec_pkg;

  // Fixed field widths of the ports.
  localparam int PORT_TIME_W = 40;
  localparam int WINDOW_W    = 20;
  localparam int COUNT_OUT_W = 9;
  localparam int TOTAL_W     = 32;
  localparam int SESSION_W   = 32;
  localparam int ACTION_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 40;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MONITOR = 1'd1;

  // Register reset values.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd60;

  // Request kinds.
  localparam logic REQ_LOG     = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;

  // Action codes of a log record.
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ERROR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_END    = 2'd3;

  // Control word broadcast to every cell of the entry chain.
  typedef struct packed {
    logic shift;  // every cell takes its tail-side neighbor's contents
    logic push;   // a new entry is appended at the tail
  } chain_ctrl_t;

endpackage

// ===== sv/wec_cell.sv =====
// ----------------------------------------------------------------------------
// Entry chain cell
// Holds one queued event (timestamp and create flag) and passes it toward
// the head when the chain shifts.
// ----------------------------------------------------------------------------
module wec_cell
  import wec_pkg::*;
#(
  parameter int TW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_ctrl_t   ctrl,
  input  logic          prev_valid,
  input  logic          nbr_valid,
  input  logic [TW-1:0] nbr_stamp,
  input  logic          nbr_create,
  input  logic [TW-1:0] new_stamp,
  input  logic          new_create,
  output logic          cell_valid,
  output logic [TW-1:0] cell_stamp,
  output logic          cell_create
);

  logic load;

  // The first empty cell behind a filled one takes an appended word.
  assign load = ctrl.push && !cell_valid && prev_valid;

  // Occupancy bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctrl.shift) begin
      cell_valid <= nbr_valid;
    end else if (load) begin
      cell_valid <= 1'b1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_stamp  <= nbr_stamp;
      cell_create <= nbr_create;
    end else if (load) begin
      cell_stamp  <= new_stamp;
      cell_create <= new_create;
    end
  end

endmodule

// ===== sv/wec_chain.sv =====
// ----------------------------------------------------------------------------
// Entry chain
// A row of cells forming a queue in arrival order; cell zero is the head.
// A shift drops the head, and when combined with a push it appends at the
// far end, which is how a full queue displaces its oldest entry.
// ----------------------------------------------------------------------------
module wec_chain
  import wec_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int TW    = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  chain_ctrl_t      ctrl,
  input  logic [TW-1:0]    new_stamp,
  input  logic             new_create,
  output logic             head_valid,
  output logic [TW-1:0]    head_stamp,
  output logic             head_create,
  output logic             full,
  output logic [DEPTH-1:0] valid_vec
);

  logic [TW-1:0] stamp_arr [DEPTH];
  logic          create_arr [DEPTH];

  // Each cell looks at its head-side neighbor for fill order and at its
  // tail-side neighbor for shifting.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          prev_v;
    logic          nbr_v;
    logic [TW-1:0] nbr_s;
    logic          nbr_c;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = valid_vec[i-1];
    end

    // Beyond the last cell sits the incoming word when a push goes along.
    if (i == DEPTH - 1) begin : g_last
      assign nbr_v = ctrl.push;
      assign nbr_s = new_stamp;
      assign nbr_c = new_create;
    end else begin : g_inner
      assign nbr_v = valid_vec[i+1];
      assign nbr_s = stamp_arr[i+1];
      assign nbr_c = create_arr[i+1];
    end

    wec_cell #(
      .TW(TW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .nbr_valid  (nbr_v),
      .nbr_stamp  (nbr_s),
      .nbr_create (nbr_c),
      .new_stamp  (new_stamp),
      .new_create (new_create),
      .cell_valid (valid_vec[i]),
      .cell_stamp (stamp_arr[i]),
      .cell_create(create_arr[i])
    );
  end

  // Head view and fill status.
  assign head_valid  = valid_vec[0];
  assign head_stamp  = stamp_arr[0];
  assign head_create = create_arr[0];
  assign full        = valid_vec[DEPTH-1];

endmodule

// ===== sv/windowed_event_counter_unit.sv =====
// Log record: its result word is registered at the edge that accepts it.
// Refresh: the cutoff is registered on acceptance, expired head entries leave
//   the chain one by one, then the result is posted once the slot is free.
// The next word is taken once the previous refresh has posted its result.
// Reset (synchronous): chain emptied through its valid bits, counters, totals
//   and start stamp cleared, window_seconds to 60, monitor_start_time to 0.
// ----------------------------------------------------------------------------
// Windowed event counter top level
// Counts session events, queues them in a chain of cells in arrival order,
// and in every result reports the creates and other events inside the window.
// ----------------------------------------------------------------------------
`include "windowed_event_counter_unit_assert.svh"

module windowed_event_counter_unit
  import wec_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256,
  parameter int TIME_BITS   = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input words
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   req_type,
  input  logic [PORT_TIME_W-1:0] event_time,
  input  logic [ACTION_W-1:0]    action_code,
  input  logic [SESSION_W-1:0]   session_number,
  // Result words
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [COUNT_OUT_W-1:0] window_created,
  output logic [COUNT_OUT_W-1:0] window_ended,
  output logic [TOTAL_W-1:0]     total_ended,
  output logic signed [TOTAL_W-1:0] active_sessions,
  output logic [PORT_TIME_W-1:0] last_start_time,
  output logic                   start_seen,
  output logic                   queue_overflow
);

  // Internal time width: times are masked to both TIME_BITS and the port width.
  localparam int TW = (TIME_BITS < PORT_TIME_W) ? TIME_BITS : PORT_TIME_W;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Control states.
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PRUNE = 1'b1;

  logic                   state;
  logic                   state_next;

  logic [WINDOW_W-1:0]    window_q;
  logic [TW-1:0]          monitor_q;
  logic [TW-1:0]          cutoff;

  logic [CW-1:0]          queued_creates;
  logic [CW-1:0]          queued_ends;
  logic [CW-1:0]          latched_creates;
  logic [CW-1:0]          latched_ends;
  logic [TOTAL_W-1:0]     started_total;
  logic [TOTAL_W-1:0]     ended_total;
  logic [TW-1:0]          start_stamp;
  logic                   start_flag;

  logic [CW-1:0]          queued_creates_next;
  logic [CW-1:0]          queued_ends_next;
  logic [CW-1:0]          latched_creates_next;
  logic [CW-1:0]          latched_ends_next;
  logic [TOTAL_W-1:0]     started_total_next;
  logic [TOTAL_W-1:0]     ended_total_next;
  logic [TW-1:0]          start_stamp_next;
  logic                   start_flag_next;

  logic [TW-1:0]          t_in;
  logic [TW:0]            cut_diff;
  logic [TW-1:0]          cut_raw;
  logic [TW-1:0]          cutoff_next;

  logic                   item_accept;
  logic                   rec_accept;
  logic                   ref_accept;
  logic                   is_push;
  logic                   is_start;
  logic                   is_create;
  logic                   displace;
  logic                   head_old;
  logic                   expire;
  logic                   pop;
  logic                   slot_free;
  logic                   finish;
  logic                   post;

  chain_ctrl_t            ctrl;
  logic                   head_valid;
  logic [TW-1:0]          head_stamp;
  logic                   head_create;
  logic                   chain_full;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  logic signed [TOTAL_W:0] act_diff;
  logic [TOTAL_W-1:0]      act_sat;
  logic [CW+COUNT_OUT_W-1:0] created_ext;
  logic [CW+COUNT_OUT_W-1:0] ended_ext;
  logic [PORT_TIME_W-1:0]    stamp_ext;

  // Handshake decode.
  assign slot_free   = !result_valid || !result_stall;
  assign item_stall  = rst || (state != ST_IDLE)
                       || (!slot_free && (req_type == REQ_LOG));
  assign item_accept = item_valid && !item_stall;
  assign rec_accept  = item_accept && (req_type == REQ_LOG);
  assign ref_accept  = item_accept && (req_type == REQ_REFRESH);
  assign is_push     = rec_accept && (action_code != ACT_START);
  assign is_start    = rec_accept && (action_code == ACT_START)
                       && (session_number == '0);
  assign is_create   = (action_code == ACT_CREATE);
  assign displace    = is_push && chain_full;

  // Pruning looks at the head entry against the registered cutoff.
  assign head_old = head_valid && (head_stamp < cutoff);
  assign expire   = (state == ST_PRUNE) && head_old;
  assign finish   = (state == ST_PRUNE) && !head_old && slot_free;
  assign pop      = expire || displace;
  assign post     = rec_accept || finish;

  assign ctrl.shift = pop;
  assign ctrl.push  = is_push;

  assign t_in = event_time[TW-1:0];

  // Cutoff is the later of now minus window (floored at zero) and monitor start.
  always_comb begin
    cut_diff    = {1'b0, t_in} - (TW + 1)'(window_q);
    cut_raw     = cut_diff[TW] ? '0 : cut_diff[TW-1:0];
    cutoff_next = (cut_raw < monitor_q) ? monitor_q : cut_raw;
  end

  // Queued counts follow pops from the head and pushes at the tail.
  always_comb begin
    queued_creates_next = queued_creates;
    queued_ends_next    = queued_ends;
    if (pop) begin
      if (head_create) begin
        if (queued_creates != '0) begin
          queued_creates_next = queued_creates - 1'b1;
        end
      end else begin
        if (queued_ends != '0) begin
          queued_ends_next = queued_ends - 1'b1;
        end
      end
    end
    if (is_push) begin
      if (is_create) begin
        queued_creates_next = queued_creates_next + 1'b1;
      end else begin
        queued_ends_next = queued_ends_next + 1'b1;
      end
    end
    latched_creates_next = finish ? queued_creates : latched_creates;
    latched_ends_next    = finish ? queued_ends : latched_ends;
  end

  // Running totals saturate at all ones; a real server start clears them.
  always_comb begin
    started_total_next = started_total;
    ended_total_next   = ended_total;
    start_stamp_next   = start_stamp;
    start_flag_next    = start_flag;
    if (is_start) begin
      started_total_next = '0;
      ended_total_next   = '0;
      start_stamp_next   = t_in;
      start_flag_next    = 1'b1;
    end else if (is_push) begin
      if (is_create) begin
        if (started_total != '1) begin
          started_total_next = started_total + 1'b1;
        end
      end else begin
        if (ended_total != '1) begin
          ended_total_next = ended_total + 1'b1;
        end
      end
    end
  end

  // Active sessions clamp to the signed 32-bit range.
  always_comb begin
    act_diff = $signed({1'b0, started_total_next}) - $signed({1'b0, ended_total_next});
    if (act_diff[TOTAL_W] == act_diff[TOTAL_W-1]) begin
      act_sat = act_diff[TOTAL_W-1:0];
    end else if (act_diff[TOTAL_W]) begin
      act_sat = {1'b1, {(TOTAL_W - 1){1'b0}}};
    end else begin
      act_sat = {1'b0, {(TOTAL_W - 1){1'b1}}};
    end
  end

  // Width adaptation of the reported counts and start time.
  always_comb begin
    created_ext = {{COUNT_OUT_W{1'b0}}, latched_creates_next};
    ended_ext   = {{COUNT_OUT_W{1'b0}}, latched_ends_next};
    stamp_ext   = '0;
    stamp_ext[TW-1:0] = start_stamp_next;
  end

  // Control state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ref_accept) begin
          state_next = ST_PRUNE;
        end
      end
      ST_PRUNE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      window_q        <= WINDOW_RESET;
      monitor_q       <= '0;
      queued_creates  <= '0;
      queued_ends     <= '0;
      latched_creates <= '0;
      latched_ends    <= '0;
      started_total   <= '0;
      ended_total     <= '0;
      start_stamp     <= '0;
      start_flag      <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      queued_creates  <= queued_creates_next;
      queued_ends     <= queued_ends_next;
      latched_creates <= latched_creates_next;
      latched_ends    <= latched_ends_next;
      started_total   <= started_total_next;
      ended_total     <= ended_total_next;
      start_stamp     <= start_stamp_next;
      start_flag      <= start_flag_next;
      // Configuration register writes.
      if (cfg_write) begin
        if (cfg_index == REG_WINDOW) begin
          window_q <= cfg_data[WINDOW_W-1:0];
        end else if (cfg_index == REG_MONITOR) begin
          monitor_q <= cfg_data[TW-1:0];
        end
      end
      // Result word is held until taken.
      if (post) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Cutoff and result payload need no reset.
  always_ff @(posedge clk) begin
    if (ref_accept) begin
      cutoff <= cutoff_next;
    end
    if (post) begin
      window_created  <= created_ext[COUNT_OUT_W-1:0];
      window_ended    <= ended_ext[COUNT_OUT_W-1:0];
      total_ended     <= ended_total_next;
      active_sessions <= act_sat;
      last_start_time <= stamp_ext;
      start_seen      <= start_flag_next;
      queue_overflow  <= displace;
    end
  end

  // Entry queue in arrival order.
  wec_chain #(
    .DEPTH(QUEUE_DEPTH),
    .TW   (TW)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .new_stamp  (t_in),
    .new_create (is_create),
    .head_valid (head_valid),
    .head_stamp (head_stamp),
    .head_create(head_create),
    .full       (chain_full),
    .valid_vec  (valid_vec)
  );

  // Checks on the queue bookkeeping.
  `WEC_ASSERT_SAME(a_count_match, 1'b1, ((CW + 1)'(queued_creates) + (CW + 1)'(queued_ends)) == (CW + 1)'($countones(valid_vec)), "queued counts disagree with chain occupancy")
  `WEC_ASSERT_SAME(a_chain_packed, 1'b1, (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0, "chain has a hole")
  `WEC_ASSERT_NEXT(a_overflow_flag, is_push && chain_full, result_valid && queue_overflow, "displacing record not flagged")

endmodule

// ===== tb/windowed_event_counter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Windowed event counter testbench
// Drives log records and refresh ticks into the counter, predicts every
// result word from a behavioral copy of the window logic, and compares each
// field as results leave the block, under random idling on both sides.
// ----------------------------------------------------------------------------
module windowed_event_counter_unit_tb;
  import wec_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [PORT_TIME_W-1:0] TIME_MAX = '1;
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
  localparam logic [SESSION_W-1:0] SESSION_MAX = '1;

  // One predicted result word.
  typedef struct {
    logic [COUNT_OUT_W-1:0]   created;
    logic [COUNT_OUT_W-1:0]   ended_in_window;
    logic [TOTAL_W-1:0]       ended_total;
    logic signed [TOTAL_W-1:0] active;
    logic [PORT_TIME_W-1:0]   boot_stamp;
    logic                     seen;
    logic                     overflow;
  } tally_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     item_valid;
  logic                     item_stall;
  logic                     req_type;
  logic [PORT_TIME_W-1:0]   event_time;
  logic [ACTION_W-1:0]      action_code;
  logic [SESSION_W-1:0]     session_number;
  logic                     result_valid;
  logic                     result_stall;
  logic [COUNT_OUT_W-1:0]   window_created;
  logic [COUNT_OUT_W-1:0]   window_ended;
  logic [TOTAL_W-1:0]       total_ended;
  logic signed [TOTAL_W-1:0] active_sessions;
  logic [PORT_TIME_W-1:0]   last_start_time;
  logic                     start_seen;
  logic                     queue_overflow;

  windowed_event_counter_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .req_type       (req_type),
    .event_time     (event_time),
    .action_code    (action_code),
    .session_number (session_number),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .window_created (window_created),
    .window_ended   (window_ended),
    .total_ended    (total_ended),
    .active_sessions(active_sessions),
    .last_start_time(last_start_time),
    .start_seen     (start_seen),
    .queue_overflow (queue_overflow)
  );

  // Mirror of the configuration registers.
  logic [WINDOW_W-1:0]    win_len;
  logic [PORT_TIME_W-1:0] win_floor;

  // Mirror of the event queue and the running totals.
  logic [PORT_TIME_W-1:0] ent_time [DEPTH];
  logic                   ent_create [DEPTH];
  int                     ent_head;
  int                     ent_tail;
  int                     ent_count;
  int                     queued_new;
  int                     queued_done;
  int                     latched_new;
  int                     latched_done;
  logic [TOTAL_W-1:0]     started_cnt;
  logic [TOTAL_W-1:0]     ended_cnt;
  logic [PORT_TIME_W-1:0] start_stamp;
  logic                   start_mark;

  tally_t                 expected_tallies[$];
  int                     mismatch_count = 0;
  bit                     no_idle = 1'b0;
  logic [PORT_TIME_W-1:0] clock_now;

  // Long receiver hold-off, requested by bumping hold_serial.
  int                     hold_len = 0;
  int                     hold_serial = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  // Removes the oldest queued event and uncounts its kind.
  function automatic void drop_oldest();
    if (ent_count == 0) return;
    if (ent_create[ent_head]) begin
      if (queued_new > 0) queued_new--;
    end else if (queued_done > 0) begin
      queued_done--;
    end
    ent_head = (ent_head + 1) % DEPTH;
    ent_count--;
  endfunction

  // Appends an event; returns 1 when the oldest one had to make room.
  function automatic bit append_event(input logic [PORT_TIME_W-1:0] t, input logic is_new);
    bit displaced;
    displaced = 1'b0;
    if (ent_count >= DEPTH) begin
      drop_oldest();
      displaced = 1'b1;
    end
    ent_time[ent_tail] = t;
    ent_create[ent_tail] = is_new;
    ent_tail = (ent_tail + 1) % DEPTH;
    ent_count++;
    if (is_new) queued_new++;
    else queued_done++;
    return displaced;
  endfunction

  // Applies one accepted word to the mirror and returns the result it yields.
  function automatic tally_t predict_tally(input logic rq, input logic [PORT_TIME_W-1:0] t,
                                           input logic [ACTION_W-1:0] act,
                                           input logic [SESSION_W-1:0] sess);
    tally_t                 res;
    logic [PORT_TIME_W-1:0] cutoff;
    longint                 diff;
    res.overflow = 1'b0;
    if (rq == REQ_REFRESH) begin
      cutoff = (t >= PORT_TIME_W'(win_len)) ? t - PORT_TIME_W'(win_len) : '0;
      if (cutoff < win_floor) cutoff = win_floor;
      while (ent_count > 0 && ent_time[ent_head] < cutoff) drop_oldest();
      latched_new = queued_new;
      latched_done = queued_done;
    end else if (act == ACT_START) begin
      // Only a start with session zero is a real server start.
      if (sess == '0) begin
        start_stamp = t;
        start_mark = 1'b1;
        started_cnt = '0;
        ended_cnt = '0;
      end
    end else if (act == ACT_CREATE) begin
      if (started_cnt != '1) started_cnt++;
      res.overflow = append_event(t, 1'b1);
    end else begin
      if (ended_cnt != '1) ended_cnt++;
      res.overflow = append_event(t, 1'b0);
    end
    diff = longint'(started_cnt) - longint'(ended_cnt);
    if (diff > 64'sd2147483647) diff = 64'sd2147483647;
    if (diff < -64'sd2147483648) diff = -64'sd2147483648;
    res.created = COUNT_OUT_W'(latched_new);
    res.ended_in_window = COUNT_OUT_W'(latched_done);
    res.ended_total = ended_cnt;
    res.active = diff[TOTAL_W-1:0];
    res.boot_stamp = start_stamp;
    res.seen = start_mark;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
  endtask

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    tally_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("unexpected result word", 64'd1, 64'd0);
      end else begin
        want = expected_tallies.pop_front();
        if (window_created !== want.created)
          report_mismatch("window_created", 64'(window_created), 64'(want.created));
        if (window_ended !== want.ended_in_window)
          report_mismatch("window_ended", 64'(window_ended), 64'(want.ended_in_window));
        if (total_ended !== want.ended_total)
          report_mismatch("total_ended", 64'(total_ended), 64'(want.ended_total));
        if (active_sessions !== want.active)
          report_mismatch("active_sessions", 64'(active_sessions), 64'(want.active));
        if (last_start_time !== want.boot_stamp)
          report_mismatch("last_start_time", 64'(last_start_time), 64'(want.boot_stamp));
        if (start_seen !== want.seen)
          report_mismatch("start_seen", 64'(start_seen), 64'(want.seen));
        if (queue_overflow !== want.overflow)
          report_mismatch("queue_overflow", 64'(queue_overflow), 64'(want.overflow));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : receiver
    int burst_left;
    int hold_left;
    int hold_taken;
    burst_left = 0;
    hold_left = 0;
    hold_taken = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_taken != hold_serial) begin
        hold_taken = hold_serial;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        result_stall = 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(0, 12);
        result_stall = 1'b1;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Offers one word, waits for its handshake and records its prediction.
  task automatic send_word(input logic rq, input logic [PORT_TIME_W-1:0] t,
                           input logic [ACTION_W-1:0] act, input logic [SESSION_W-1:0] sess);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = rq;
    event_time = t;
    action_code = act;
    session_number = sess;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    expected_tallies.push_back(predict_tally(rq, t, act, sess));
  endtask

  task automatic send_log(input logic [ACTION_W-1:0] act, input logic [PORT_TIME_W-1:0] t,
                          input logic [SESSION_W-1:0] sess);
    send_word(REQ_LOG, t, act, sess);
  endtask

  // A refresh carries don't-care action and session fields.
  task automatic send_refresh(input logic [PORT_TIME_W-1:0] t);
    send_word(REQ_REFRESH, t, ACTION_W'($urandom_range(0, 3)), SESSION_W'($urandom));
  endtask

  // Stops offering and waits until every predicted result has left.
  task automatic settle_block();
    @(negedge clk);
    item_valid = 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_WINDOW) win_len = data[WINDOW_W-1:0];
    else win_floor = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // One random word around the running clock; a few are pure noise.
  task automatic send_random_word(input int unsigned win);
    int                     roll;
    int unsigned            jitter;
    logic [PORT_TIME_W-1:0] t;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      t = {8'($urandom), 32'($urandom)};
      send_word(1'($urandom), t, ACTION_W'($urandom_range(0, 3)), SESSION_W'($urandom));
    end else if (roll < 32) begin
      send_refresh(clock_now);
    end else if (roll < 37) begin
      send_log(ACT_START, clock_now, '0);
    end else if (roll < 40) begin
      send_log(ACT_START, clock_now, SESSION_W'($urandom) | SESSION_W'(1));
    end else begin
      jitter = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * win + 2) : 0;
      t = (clock_now >= jitter) ? clock_now - jitter : '0;
      send_log(ACTION_W'($urandom_range(1, 3)), t, SESSION_W'($urandom));
    end
    clock_now = clock_now + $urandom_range(0, win / 3 + 2);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Edge values of every field, every action and each corner of the window.
  task automatic test_directed();
    send_refresh('0);
    send_log(ACT_START, 40'd100, '0);
    send_log(ACT_START, 40'd200, 32'd1);
    send_log(ACT_START, 40'd300, SESSION_MAX);
    send_log(ACT_CREATE, 40'd110, SESSION_MAX);
    send_log(ACT_ERROR, 40'd115, '0);
    send_log(ACT_END, 40'd120, 32'd12345);
    send_log(ACT_CREATE, TIME_MAX, 32'd7);
    // Out of order: sits behind a newer entry and survives pruning.
    send_log(ACT_CREATE, 40'd50, 32'd8);
    send_refresh(40'd130);
    // Current time below the window length: cutoff falls back to the floor.
    send_refresh(40'd30);
    send_refresh(40'd200);
    send_refresh(TIME_MAX);
    send_log(ACT_END, '0, 32'd9);
    // A server start clears the totals but keeps the queue.
    send_log(ACT_START, TIME_MAX, '0);
    send_refresh(TIME_MAX);
    send_log(ACT_START, '0, '0);
    send_refresh(40'd60);
  endtask

  // Extreme register settings, then back to the reset values.
  task automatic test_config_extremes();
    settle_block();
    cfg_put(REG_WINDOW, '0);
    cfg_put(REG_MONITOR, TIME_MAX);
    send_log(ACT_CREATE, 40'd5, 32'd1);
    send_log(ACT_END, TIME_MAX, 32'd2);
    send_refresh(40'd10);
    send_refresh(TIME_MAX);
    settle_block();
    cfg_put(REG_WINDOW, CFG_DATA_W'(WINDOW_MAX));
    cfg_put(REG_MONITOR, '0);
    send_log(ACT_ERROR, 40'd3, 32'd3);
    send_refresh('0);
    send_refresh(TIME_MAX);
    settle_block();
    cfg_put(REG_WINDOW, CFG_DATA_W'(WINDOW_RESET));
    cfg_put(REG_MONITOR, '0);
  endtask

  // More records than the queue holds, so the oldest are pushed out.
  task automatic test_overflow();
    logic [PORT_TIME_W-1:0] t;
    settle_block();
    cfg_put(REG_WINDOW, CFG_DATA_W'(WINDOW_MAX));
    cfg_put(REG_MONITOR, '0);
    t = 40'd1000;
    repeat (DEPTH + 40) begin
      send_log(ACTION_W'($urandom_range(1, 3)), t, SESSION_W'($urandom));
      t = t + $urandom_range(0, 3);
    end
    send_refresh(t);
    send_refresh(t + 40'd2000000);
  endtask

  // The receiver holds off for a long time while words keep coming.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_len = 300;
    hold_serial++;
    clock_now = 40'd5000;
    repeat (40) send_random_word(50);
    no_idle = 1'b0;
  endtask

  // Random phases under different settings; the last one runs without idling.
  task automatic test_random();
    int unsigned            win;
    logic [PORT_TIME_W-1:0] floor_t;
    for (int phase = 0; phase < 5; phase++) begin
      settle_block();
      unique case (phase)
        0: begin
          win = 30;
          floor_t = '0;
        end
        1: begin
          win = $urandom_range(1, 400);
          floor_t = clock_now + $urandom_range(0, 300);
        end
        2: begin
          win = 0;
          floor_t = ($urandom_range(0, 1) == 0) ? '0 : clock_now;
        end
        3: begin
          clock_now = TIME_MAX - 40'h00_8000_0000 - $urandom_range(0, 1000);
          win = $urandom_range(500000, 1048575);
          floor_t = clock_now - $urandom_range(0, 2000000);
        end
        default: begin
          win = 32'(WINDOW_RESET);
          floor_t = '0;
          no_idle = 1'b1;
        end
      endcase
      // Upper data bits are beyond the window register and must not matter.
      cfg_put(REG_WINDOW, {20'($urandom), WINDOW_W'(win)});
      cfg_put(REG_MONITOR, floor_t);
      repeat (180) send_random_word(win);
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    int guard;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    item_valid = 1'b0;
    req_type = REQ_LOG;
    event_time = '0;
    action_code = ACT_START;
    session_number = '0;

    // Mirror state matches the block after reset.
    win_len = WINDOW_RESET;
    win_floor = '0;
    ent_head = 0;
    ent_tail = 0;
    ent_count = 0;
    queued_new = 0;
    queued_done = 0;
    latched_new = 0;
    latched_done = 0;
    started_cnt = '0;
    ended_cnt = '0;
    start_stamp = '0;
    start_mark = 1'b0;
    clock_now = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config_extremes();
    test_overflow();
    test_backpressure();
    test_random();

    // Drain, then give a slow refresh time to show any stray word.
    @(negedge clk);
    item_valid = 1'b0;
    guard = 0;
    while (expected_tallies.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
    if (expected_tallies.size() != 0)
      report_mismatch("missing result words", 64'd0, 64'(expected_tallies.size()));

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wec_pkg.sv
sv/wec_cell.sv
sv/wec_chain.sv
sv/windowed_event_counter_unit.sv
tb/windowed_event_counter_unit_tb.sv
